// ===== rtl/msp_pkg.sv =====
// Shared types and constants for the multi-slice PWM counter.
// No dependencies; imported by every other file of the block.
package msp_pkg;

  // Item kinds; the fourth code changes no register and reads as zero
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  // Register selects
  typedef enum logic [3:0] {
    REG_CTRL    = 4'd0,
    REG_DIV     = 4'd1,
    REG_COUNT   = 4'd2,
    REG_LEVEL_A = 4'd3,
    REG_LEVEL_B = 4'd4,
    REG_WRAP    = 4'd5,
    REG_EN_MASK = 4'd6,
    REG_CLEAR   = 4'd7,
    REG_IRQ_EN  = 4'd8,
    REG_STATUS  = 4'd9
  } reg_sel_e;

  localparam int unsigned MaxSlices = 8;

  localparam logic [12:0] PhaseStep = 13'h010;
  localparam logic [15:0] DivMin    = 16'd16;
  localparam logic [15:0] DivMax    = 16'd4094;
  localparam logic [11:0] DivReset  = 12'd16;
  localparam logic [15:0] WrapReset = 16'hFFFF;

  // Control register bit positions
  localparam int unsigned CtrlEnBit   = 0;
  localparam int unsigned CtrlInvABit = 2;
  localparam int unsigned CtrlInvBBit = 3;

  // Configuration register index
  localparam logic CfgIrqMaster = 1'b0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slice_index;
    logic [3:0]  register_select;
    logic [15:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        irq_line;
    logic [7:0]  irq_status_out;
  } out_item_t;

  // Command from the decode logic to one slice
  typedef struct packed {
    logic        tick;
    logic        wr;
    logic        mask_wr;
    logic        mask_bit;
    logic [3:0]  reg_sel;
    logic [15:0] wdata;
  } slice_cmd_t;

  // Status returned by one slice
  typedef struct packed {
    logic        enable;
    logic        wrapped;
    logic [15:0] rdata;
  } slice_stat_t;

endpackage

// ===== rtl/msp_slice.sv =====
// One PWM slice: fractional divider, counter, compare levels and wrap value.
// Depends on msp_pkg.
module msp_slice (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  msp_pkg::slice_cmd_t cmd_i,
  output msp_pkg::slice_stat_t stat_o
);
  import msp_pkg::*;

  logic        en_q, en_d;
  logic        inv_a_q, inv_a_d;
  logic        inv_b_q, inv_b_d;
  logic [11:0] div_q, div_d;
  logic [11:0] phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] lvl_a_q, lvl_a_d;
  logic [15:0] lvl_b_q, lvl_b_d;
  logic [15:0] wrap_q, wrap_d;
  logic [12:0] acc;
  logic [11:0] div_clamped;
  logic        wrapped;

  always_comb begin
    if (cmd_i.wdata < DivMin) begin
      div_clamped = DivMin[11:0];
    end else if (cmd_i.wdata > DivMax) begin
      div_clamped = DivMax[11:0];
    end else begin
      div_clamped = cmd_i.wdata[11:0];
    end
  end

  always_comb begin
    en_d    = en_q;
    inv_a_d = inv_a_q;
    inv_b_d = inv_b_q;
    div_d   = div_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    lvl_a_d = lvl_a_q;
    lvl_b_d = lvl_b_q;
    wrap_d  = wrap_q;
    wrapped = 1'b0;
    acc     = {1'b0, phase_q} + PhaseStep;

    if (cmd_i.tick && en_q) begin
      if (acc >= {1'b0, div_q}) begin
        acc = acc - {1'b0, div_q};
        if (cnt_q == wrap_q) begin
          cnt_d   = '0;
          wrapped = 1'b1;
        end else begin
          cnt_d = cnt_q + 16'd1;
        end
      end
      phase_d = acc[11:0];
    end

    if (cmd_i.wr) begin
      case (cmd_i.reg_sel)
        REG_CTRL: begin
          en_d    = cmd_i.wdata[CtrlEnBit];
          inv_a_d = cmd_i.wdata[CtrlInvABit];
          inv_b_d = cmd_i.wdata[CtrlInvBBit];
        end
        REG_DIV: begin
          div_d   = div_clamped;
          phase_d = '0;
        end
        REG_COUNT:   cnt_d   = cmd_i.wdata;
        REG_LEVEL_A: lvl_a_d = cmd_i.wdata;
        REG_LEVEL_B: lvl_b_d = cmd_i.wdata;
        REG_WRAP:    wrap_d  = cmd_i.wdata;
        default: ;
      endcase
    end

    if (cmd_i.mask_wr) begin
      en_d = cmd_i.mask_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      inv_a_q <= 1'b0;
      inv_b_q <= 1'b0;
      div_q   <= DivReset;
      phase_q <= '0;
      cnt_q   <= '0;
      lvl_a_q <= '0;
      lvl_b_q <= '0;
      wrap_q  <= WrapReset;
    end else begin
      en_q    <= en_d;
      inv_a_q <= inv_a_d;
      inv_b_q <= inv_b_d;
      div_q   <= div_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      lvl_a_q <= lvl_a_d;
      lvl_b_q <= lvl_b_d;
      wrap_q  <= wrap_d;
    end
  end

  always_comb begin
    stat_o.enable  = en_q;
    stat_o.wrapped = wrapped;
    case (cmd_i.reg_sel)
      REG_CTRL:    stat_o.rdata = {12'd0, inv_b_q, inv_a_q, 1'b0, en_q};
      REG_DIV:     stat_o.rdata = {4'd0, div_q};
      REG_COUNT:   stat_o.rdata = cnt_q;
      REG_LEVEL_A: stat_o.rdata = lvl_a_q;
      REG_LEVEL_B: stat_o.rdata = lvl_b_q;
      REG_WRAP:    stat_o.rdata = wrap_q;
      default:     stat_o.rdata = '0;
    endcase
  end

endmodule

// ===== rtl/msp_apb.sv =====
// APB-style configuration port holding the interrupt master enable.
// Depends on msp_pkg.
module msp_apb (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        irq_master_o
);
  import msp_pkg::*;

  logic master_q, master_d;
  logic hit;

  assign hit    = (paddr[2] == CfgIrqMaster);
  assign pready = 1'b1;

  always_comb begin
    master_d = master_q;
    if (psel && penable && pwrite && hit) begin
      master_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= 1'b0;
    end else begin
      master_q <= master_d;
    end
  end

  assign prdata       = hit ? {31'd0, master_q} : 32'd0;
  assign irq_master_o = master_q;

endmodule

// ===== rtl/multi_slice_pwm_counter.sv =====
// Top level of the multi-slice PWM counter: input register, decode, slice bank,
// global interrupt registers and result register. Depends on msp_pkg, msp_slice, msp_apb.

// Each transfer (tick, register write or register read) is registered in the
// input register, then executed against the slice bank and the interrupt
// registers, and its single result lands in the output register. One item is
// taken every cycle as long as the output side does not stall. Every slice
// advances in parallel on a tick, so throughput does not depend on NUM_SLICES.
module multi_slice_pwm_counter #(
  parameter int unsigned NUM_SLICES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  msp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output msp_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import msp_pkg::*;

  in_item_t  in_q;
  logic      in_valid_q, in_valid_d;
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;
  logic      in_xfer, fire, irq_master;

  logic [NUM_SLICES-1:0] ien_q, ien_d;
  logic [NUM_SLICES-1:0] status_q, status_d;
  logic [NUM_SLICES-1:0] hit, en_vec, wrap_vec;
  logic [15:0]           slice_rd;
  logic [15:0]           rd;

  slice_cmd_t  cmd [NUM_SLICES];
  slice_stat_t stat [NUM_SLICES];

  msp_apb u_apb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .irq_master_o (irq_master)
  );

  // Execute when the result register is free or being emptied
  assign fire       = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
  end

  for (genvar s = 0; s < NUM_SLICES; s++) begin : g_slice
    always_comb begin
      hit[s]              = (in_q.slice_index == 3'(s));
      cmd[s].tick         = fire && (in_q.kind == KIND_TICK);
      cmd[s].wr           = fire && (in_q.kind == KIND_WRITE) && hit[s];
      cmd[s].mask_wr      = fire && (in_q.kind == KIND_WRITE)
                            && (in_q.register_select == REG_EN_MASK);
      cmd[s].mask_bit     = in_q.write_data[s];
      cmd[s].reg_sel      = in_q.register_select;
      cmd[s].wdata        = in_q.write_data;
      en_vec[s]           = stat[s].enable;
      wrap_vec[s]         = stat[s].wrapped;
    end

    msp_slice u_slice (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[s]),
      .stat_o (stat[s])
    );
  end

  // Slice read mux; no hit for an out-of-range index gives zero
  always_comb begin
    slice_rd = '0;
    for (int s = 0; s < NUM_SLICES; s++) begin
      slice_rd = slice_rd | (stat[s].rdata & {16{hit[s]}});
    end
  end

  always_comb begin
    case (in_q.register_select)
      REG_EN_MASK: rd = 16'(en_vec);
      REG_IRQ_EN:  rd = 16'(ien_q);
      REG_STATUS:  rd = 16'(status_q);
      REG_CLEAR:   rd = '0;
      default:     rd = slice_rd;
    endcase
    if (in_q.kind != KIND_READ) begin
      rd = '0;
    end
  end

  always_comb begin
    ien_d    = ien_q;
    status_d = status_q;
    if (fire) begin
      if (in_q.kind == KIND_TICK) begin
        status_d = status_q | (wrap_vec & ien_q);
      end else if (in_q.kind == KIND_WRITE) begin
        unique case (in_q.register_select)
          REG_CLEAR:  status_d = status_q & ~in_q.write_data[NUM_SLICES-1:0];
          REG_IRQ_EN: ien_d    = in_q.write_data[NUM_SLICES-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    out_d.read_data      = rd;
    out_d.irq_line       = irq_master && (|(status_d & ien_d));
    out_d.irq_status_out = 8'(status_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ien_q       <= '0;
      status_q    <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      ien_q       <= ien_d;
      status_q    <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Input side only stalls behind a full, stalled result register
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  // Status only moves on an executed item, which also reloads the result
  a_status_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.irq_status_out == 8'(status_q)))
    else $error("held result disagrees with interrupt status");

  // Interrupt line implies a pending enabled status bit
  a_irq_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.irq_line) |-> (|out_data_o.irq_status_out))
    else $error("interrupt line raised with empty status");

endmodule
